>>> sv/hcalu_pkg.sv
// ----------------------------------------------------------------------------
// hcalu_pkg
// Shared command codes, flag positions and pipeline stage records for the
// handheld CPU ALU.
// ----------------------------------------------------------------------------
package hcalu_pkg;

  // command codes
  localparam logic [4:0] CMD_ADD   = 5'd0;
  localparam logic [4:0] CMD_ADC   = 5'd1;
  localparam logic [4:0] CMD_SUB   = 5'd2;
  localparam logic [4:0] CMD_SBC   = 5'd3;
  localparam logic [4:0] CMD_AND   = 5'd4;
  localparam logic [4:0] CMD_XOR   = 5'd5;
  localparam logic [4:0] CMD_OR    = 5'd6;
  localparam logic [4:0] CMD_CP    = 5'd7;
  localparam logic [4:0] CMD_INC8  = 5'd8;
  localparam logic [4:0] CMD_DEC8  = 5'd9;
  localparam logic [4:0] CMD_RLC   = 5'd10;
  localparam logic [4:0] CMD_RRC   = 5'd11;
  localparam logic [4:0] CMD_RL    = 5'd12;
  localparam logic [4:0] CMD_RR    = 5'd13;
  localparam logic [4:0] CMD_SLA   = 5'd14;
  localparam logic [4:0] CMD_SRA   = 5'd15;
  localparam logic [4:0] CMD_SWAP  = 5'd16;
  localparam logic [4:0] CMD_SRL   = 5'd17;
  localparam logic [4:0] CMD_BIT   = 5'd18;
  localparam logic [4:0] CMD_RES   = 5'd19;
  localparam logic [4:0] CMD_SET   = 5'd20;
  localparam logic [4:0] CMD_RLCA  = 5'd21;
  localparam logic [4:0] CMD_RRCA  = 5'd22;
  localparam logic [4:0] CMD_DAA   = 5'd23;
  localparam logic [4:0] CMD_ADD16 = 5'd24;
  localparam logic [4:0] CMD_ADDSP = 5'd25;
  localparam logic [4:0] CMD_INC16 = 5'd26;
  localparam logic [4:0] CMD_DEC16 = 5'd27;

  // flag bit positions in the packed ZNHC nibble
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  // decimal adjust constants
  localparam logic [8:0] DAA_LO_ADJ = 9'h006;
  localparam logic [8:0] DAA_HI_ADJ = 9'h060;
  localparam logic [8:0] DAA_HI_LIM = 9'h09F;
  localparam logic [3:0] DAA_NIB_LIM = 4'd9;

  // stage 1 record: operands with adder inputs already steered
  typedef struct packed {
    logic [4:0]  cmd;
    logic [15:0] x;
    logic [7:0]  b;
    logic [3:0]  flags;
    logic [7:0]  op8;
    logic        cin8;
    logic [15:0] op16;
    logic [7:0]  mask;
  } prep_t;

  // stage 2 record: raw result, partial flags, zero-test source
  typedef struct packed {
    logic [4:0]  cmd;
    logic [3:0]  flags;
    logic [15:0] val;
    logic [7:0]  zsrc;
    logic        zmode;
    logic [3:0]  flg;
    logic [8:0]  daa_t;
  } exec_t;

endpackage

>>> sv/hcalu_prep.sv
// ----------------------------------------------------------------------------
// hcalu_prep
// Stage 1: captures a transaction and steers adder operands, carry-in and
// bit mask per command.
// ----------------------------------------------------------------------------
module hcalu_prep (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [4:0]         command_i,
  input  logic [15:0]        first_operand_i,
  input  logic [15:0]        second_operand_i,
  input  logic [2:0]         bit_index_i,
  input  logic [3:0]         flags_in_i,
  output logic               valid_o,
  output hcalu_pkg::prep_t   prep_o
);
  import hcalu_pkg::*;

  logic        valid_q;
  prep_t       prep_q, prep_d;
  logic [7:0]  b;
  logic        c_in;

  assign b    = second_operand_i[7:0];
  assign c_in = flags_in_i[FLAG_C];

  always_comb begin
    prep_d.cmd   = command_i;
    prep_d.x     = first_operand_i;
    prep_d.b     = b;
    prep_d.flags = flags_in_i;
    prep_d.mask  = 8'h01 << bit_index_i;

    // 8-bit adder: subtract is a + ~b + ~borrow
    case (command_i)
      CMD_ADD: begin
        prep_d.op8 = b;        prep_d.cin8 = 1'b0;
      end
      CMD_ADC: begin
        prep_d.op8 = b;        prep_d.cin8 = c_in;
      end
      CMD_SUB, CMD_CP: begin
        prep_d.op8 = ~b;       prep_d.cin8 = 1'b1;
      end
      CMD_SBC: begin
        prep_d.op8 = ~b;       prep_d.cin8 = ~c_in;
      end
      CMD_INC8: begin
        prep_d.op8 = 8'h00;    prep_d.cin8 = 1'b1;
      end
      CMD_DEC8: begin
        prep_d.op8 = 8'hFF;    prep_d.cin8 = 1'b0;
      end
      default: begin
        prep_d.op8 = b;        prep_d.cin8 = 1'b0;
      end
    endcase

    // 16-bit adder second input
    case (command_i)
      CMD_ADDSP: prep_d.op16 = {{8{b[7]}}, b};
      CMD_INC16: prep_d.op16 = 16'h0001;
      CMD_DEC16: prep_d.op16 = 16'hFFFF;
      default:   prep_d.op16 = second_operand_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prep_q <= prep_d;
    end
  end

  assign valid_o = valid_q;
  assign prep_o  = prep_q;

endmodule

>>> sv/hcalu_exec.sv
// ----------------------------------------------------------------------------
// hcalu_exec
// Stage 2: 8-bit and 16-bit adders, logic, shifts, bit ops and the first
// decimal-adjust step; flags except the zero test.
// ----------------------------------------------------------------------------
module hcalu_exec (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  hcalu_pkg::prep_t   prep_i,
  output logic               valid_o,
  output hcalu_pkg::exec_t   exec_o
);
  import hcalu_pkg::*;

  logic        valid_q;
  exec_t       exec_q, exec_d;
  logic [7:0]  a;
  logic [8:0]  sum8;
  logic [16:0] sum16;
  logic        c4_8, c8_8, c4_16, c8_16, c12_16;
  logic [3:0]  f;
  logic [7:0]  r8;

  assign a = prep_i.x[7:0];
  assign f = prep_i.flags;

  always_comb begin
    sum8   = {1'b0, a} + {1'b0, prep_i.op8} + {8'h00, prep_i.cin8};
    c4_8   = sum8[4] ^ a[4] ^ prep_i.op8[4];
    c8_8   = sum8[8];
    sum16  = {1'b0, prep_i.x} + {1'b0, prep_i.op16};
    // carry into bit n = sum ^ x ^ y at bit n
    c4_16  = sum16[4] ^ prep_i.x[4] ^ prep_i.op16[4];
    c8_16  = sum16[8] ^ prep_i.x[8] ^ prep_i.op16[8];
    c12_16 = sum16[12] ^ prep_i.x[12] ^ prep_i.op16[12];

    exec_d.cmd   = prep_i.cmd;
    exec_d.flags = f;

    // decimal adjust, first correction
    if (!f[FLAG_N]) begin
      exec_d.daa_t = (f[FLAG_H] || (a[3:0] > DAA_NIB_LIM)) ? ({1'b0, a} + DAA_LO_ADJ)
                                                           : {1'b0, a};
    end else begin
      exec_d.daa_t = f[FLAG_H] ? {1'b0, a - DAA_LO_ADJ[7:0]} : {1'b0, a};
    end

    r8           = 8'h00;
    exec_d.zmode = 1'b0;
    exec_d.flg   = f;
    exec_d.zsrc  = 8'h00;
    exec_d.val   = 16'h0000;

    case (prep_i.cmd)
      CMD_ADD, CMD_ADC: begin
        r8 = sum8[7:0];  exec_d.zmode = 1'b1;
        exec_d.flg = {1'b0, 1'b0, c4_8, c8_8};
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        r8 = sum8[7:0];  exec_d.zmode = 1'b1;
        exec_d.flg = {1'b0, 1'b1, ~c4_8, ~c8_8};
      end
      CMD_AND: begin
        r8 = a & prep_i.b;  exec_d.zmode = 1'b1;
        exec_d.flg = 4'b0010;
      end
      CMD_XOR: begin
        r8 = a ^ prep_i.b;  exec_d.zmode = 1'b1;
        exec_d.flg = 4'b0000;
      end
      CMD_OR: begin
        r8 = a | prep_i.b;  exec_d.zmode = 1'b1;
        exec_d.flg = 4'b0000;
      end
      CMD_INC8: begin
        r8 = sum8[7:0];  exec_d.zmode = 1'b1;
        exec_d.flg = {1'b0, 1'b0, c4_8, f[FLAG_C]};
      end
      CMD_DEC8: begin
        r8 = sum8[7:0];  exec_d.zmode = 1'b1;
        exec_d.flg = {1'b0, 1'b1, ~c4_8, f[FLAG_C]};
      end
      CMD_RLC, CMD_RLCA: begin
        r8 = {a[6:0], a[7]};  exec_d.zmode = (prep_i.cmd == CMD_RLC);
        exec_d.flg = {3'b000, a[7]};
      end
      CMD_RRC, CMD_RRCA: begin
        r8 = {a[0], a[7:1]};  exec_d.zmode = (prep_i.cmd == CMD_RRC);
        exec_d.flg = {3'b000, a[0]};
      end
      CMD_RL: begin
        r8 = {a[6:0], f[FLAG_C]};  exec_d.zmode = 1'b1;
        exec_d.flg = {3'b000, a[7]};
      end
      CMD_RR: begin
        r8 = {f[FLAG_C], a[7:1]};  exec_d.zmode = 1'b1;
        exec_d.flg = {3'b000, a[0]};
      end
      CMD_SLA: begin
        r8 = {a[6:0], 1'b0};  exec_d.zmode = 1'b1;
        exec_d.flg = {3'b000, a[7]};
      end
      CMD_SRA: begin
        r8 = {a[7], a[7:1]};  exec_d.zmode = 1'b1;
        exec_d.flg = {3'b000, a[0]};
      end
      CMD_SWAP: begin
        r8 = {a[3:0], a[7:4]};  exec_d.zmode = 1'b1;
        exec_d.flg = 4'b0000;
      end
      CMD_SRL: begin
        r8 = {1'b0, a[7:1]};  exec_d.zmode = 1'b1;
        exec_d.flg = {3'b000, a[0]};
      end
      CMD_BIT: begin
        r8 = a;  exec_d.zmode = 1'b1;
        exec_d.flg = {1'b0, 1'b0, 1'b1, f[FLAG_C]};
      end
      CMD_RES: r8 = a & ~prep_i.mask;
      CMD_SET: r8 = a | prep_i.mask;
      default: r8 = 8'h00;
    endcase

    // zero test source: bit test looks at the masked bit, others at r8
    exec_d.zsrc = (prep_i.cmd == CMD_BIT) ? (a & prep_i.mask) : r8;
    // compare echoes the operand
    exec_d.val  = (prep_i.cmd == CMD_CP) ? {8'h00, a} : {8'h00, r8};

    case (prep_i.cmd)
      CMD_ADD16: begin
        exec_d.val = sum16[15:0];
        exec_d.flg = {f[FLAG_Z], 1'b0, c12_16, sum16[16]};
      end
      CMD_ADDSP: begin
        exec_d.val = sum16[15:0];
        exec_d.flg = {2'b00, c4_16, c8_16};
      end
      CMD_INC16, CMD_DEC16: exec_d.val = sum16[15:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      exec_q <= exec_d;
    end
  end

  assign valid_o = valid_q;
  assign exec_o  = exec_q;

endmodule

>>> sv/hcalu_fin.sv
// ----------------------------------------------------------------------------
// hcalu_fin
// Stage 3: second decimal-adjust step, zero detect, flag merge and the
// output register.
// ----------------------------------------------------------------------------
module hcalu_fin (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  hcalu_pkg::exec_t   ex_i,
  output logic               done_o,
  output logic [15:0]        value_o,
  output logic [3:0]         flags_o
);
  import hcalu_pkg::*;

  logic        done_q;
  logic [15:0] value_q, value_d;
  logic [3:0]  flags_q, flags_d;
  logic [8:0]  t2;
  logic [3:0]  f;

  assign f = ex_i.flags;

  always_comb begin
    if (!f[FLAG_N]) begin
      t2 = (f[FLAG_C] || (ex_i.daa_t > DAA_HI_LIM)) ? (ex_i.daa_t + DAA_HI_ADJ)
                                                     : ex_i.daa_t;
    end else begin
      t2 = f[FLAG_C] ? (ex_i.daa_t - DAA_HI_ADJ) : ex_i.daa_t;
    end

    if (ex_i.cmd == CMD_DAA) begin
      value_d = {8'h00, t2[7:0]};
      flags_d = {(t2[7:0] == 8'h00), f[FLAG_N], 1'b0, f[FLAG_C] | t2[8]};
    end else if (ex_i.zmode) begin
      value_d = ex_i.val;
      flags_d = {(ex_i.zsrc == 8'h00), ex_i.flg[2:0]};
    end else begin
      value_d = ex_i.val;
      flags_d = ex_i.flg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      value_q <= value_d;
      flags_q <= flags_d;
    end
  end

  assign done_o  = done_q;
  assign value_o = value_q;
  assign flags_o = flags_q;

  a_daa_h_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (ex_i.cmd == CMD_DAA) |=> !flags_q[FLAG_H])
    else $error("decimal adjust left H set");

  a_byte_zext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (ex_i.cmd <= CMD_DAA) |=> (value_q[15:8] == 8'h00))
    else $error("8-bit result not zero-extended");

endmodule

>>> sv/handheld_cpu_alu_with_flags.sv
// ----------------------------------------------------------------------------
// handheld_cpu_alu_with_flags
// 8/16-bit ALU of a handheld-console CPU with ZNHC flag generation,
// three register stages.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload
//  -------   ----------------   ----------------------------------------------
//  command   start_i / busy_o   command_i, first_operand_i, second_operand_i,
//                               bit_index_i, flags_in_i
//  result    done_o (strobe)    result_value_o, flags_out_o
//
//  One transaction per clock; busy_o is never raised.
//  A start passes the prep, exec and fin registers before done_o rises.
//  Depth is set by the stage cut: operand steering, adders and shifters,
//  then the decimal-adjust high step with zero detect.
//  Reset clears the three valid bits only; no transaction is in flight after.
//  The receiver takes each result in its strobe cycle, so the pipe never
//  stalls.
//
module handheld_cpu_alu_with_flags (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [4:0]  command_i,
  input  logic [15:0] first_operand_i,
  input  logic [15:0] second_operand_i,
  input  logic [2:0]  bit_index_i,
  input  logic [3:0]  flags_in_i,
  output logic        done_o,
  output logic [15:0] result_value_o,
  output logic [3:0]  flags_out_o
);
  import hcalu_pkg::*;

  logic  prep_valid;
  prep_t prep;
  logic  exec_valid;
  exec_t exec;

  // fully pipelined, nothing to hold off
  assign busy_o = 1'b0;

  // stage 1: operand steering
  hcalu_prep u_prep (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .command_i        (command_i),
    .first_operand_i  (first_operand_i),
    .second_operand_i (second_operand_i),
    .bit_index_i      (bit_index_i),
    .flags_in_i       (flags_in_i),
    .valid_o          (prep_valid),
    .prep_o           (prep)
  );

  // stage 2: adders, logic, shifts
  hcalu_exec u_exec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .prep_i  (prep),
    .valid_o (exec_valid),
    .exec_o  (exec)
  );

  // stage 3: DAA finish, zero flag, output register
  hcalu_fin u_fin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (exec_valid),
    .ex_i    (exec),
    .done_o  (done_o),
    .value_o (result_value_o),
    .flags_o (flags_out_o)
  );

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##3 done_o)
    else $error("accepted transaction did not complete in 3 cycles");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 3))
    else $error("result strobe without a matching transaction");

endmodule

>>> dv/alu_flag_checker.sv
// ----------------------------------------------------------------------------
// alu_flag_checker
// Watches the command and result channels of the handheld CPU ALU, computes
// the expected value and ZNHC flags of every accepted transaction and
// compares them in order with the results coming out of the block.
// ----------------------------------------------------------------------------
module alu_flag_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [4:0]  command_i,
  input  logic [15:0] first_operand_i,
  input  logic [15:0] second_operand_i,
  input  logic [2:0]  bit_index_i,
  input  logic [3:0]  flags_in_i,
  input  logic        done_i,
  input  logic [15:0] result_value_i,
  input  logic [3:0]  flags_out_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import hcalu_pkg::*;

  typedef struct packed {
    logic [4:0]  cmd;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] value;
    logic [3:0]  flags;
  } alu_expect_t;

  alu_expect_t alu_results_q[$];
  alu_expect_t head;
  int          errors  = 0;
  int          checked = 0;

  function automatic alu_expect_t alu_compute(logic [4:0] cmd, logic [15:0] x,
                                              logic [15:0] y, logic [2:0] bi,
                                              logic [3:0] f);
    alu_expect_t e;
    int          ua;
    int          ub;
    int          uc;
    int          ut;
    logic [7:0]  a;
    logic [7:0]  r;
    logic [15:0] rv;
    logic        wide;
    logic [3:0]  fo;

    a    = x[7:0];
    ua   = x[7:0];
    ub   = y[7:0];
    uc   = 0;
    r    = 8'h00;
    rv   = 16'h0000;
    wide = 1'b0;
    fo   = f;

    case (cmd)
      CMD_ADD, CMD_ADC: begin
        uc = (cmd == CMD_ADC) ? int'(f[FLAG_C]) : 0;
        ut = ua + ub + uc;
        r  = ut[7:0];
        fo = 4'h0;
        fo[FLAG_Z] = (r == 8'h00);
        fo[FLAG_H] = ((ua & 15) + (ub & 15) + uc) > 15;
        fo[FLAG_C] = ut > 255;
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        uc = (cmd == CMD_SBC) ? int'(f[FLAG_C]) : 0;
        ut = ua - ub - uc;
        r  = ut[7:0];
        fo = 4'h0;
        fo[FLAG_N] = 1'b1;
        fo[FLAG_Z] = (r == 8'h00);
        fo[FLAG_H] = (ua & 15) < ((ub & 15) + uc);
        fo[FLAG_C] = ua < (ub + uc);
        if (cmd == CMD_CP) r = a;   // compare keeps the accumulator
      end
      CMD_AND: begin
        r  = a & y[7:0];
        fo = 4'h0;
        fo[FLAG_Z] = (r == 8'h00);
        fo[FLAG_H] = 1'b1;
      end
      CMD_XOR, CMD_OR: begin
        r  = (cmd == CMD_XOR) ? (a ^ y[7:0]) : (a | y[7:0]);
        fo = 4'h0;
        fo[FLAG_Z] = (r == 8'h00);
      end
      CMD_INC8: begin
        r = a + 8'd1;
        fo[FLAG_Z] = (r == 8'h00);
        fo[FLAG_N] = 1'b0;
        fo[FLAG_H] = (r[3:0] == 4'h0);
      end
      CMD_DEC8: begin
        r = a - 8'd1;
        fo[FLAG_Z] = (r == 8'h00);
        fo[FLAG_N] = 1'b1;
        fo[FLAG_H] = (a[3:0] == 4'h0);
      end
      CMD_RLC, CMD_RLCA: begin
        r  = {a[6:0], a[7]};
        fo = 4'h0;
        fo[FLAG_C] = a[7];
        fo[FLAG_Z] = (cmd == CMD_RLC) && (r == 8'h00);
      end
      CMD_RRC, CMD_RRCA: begin
        r  = {a[0], a[7:1]};
        fo = 4'h0;
        fo[FLAG_C] = a[0];
        fo[FLAG_Z] = (cmd == CMD_RRC) && (r == 8'h00);
      end
      CMD_RL, CMD_SLA: begin
        r  = {a[6:0], (cmd == CMD_RL) ? f[FLAG_C] : 1'b0};
        fo = 4'h0;
        fo[FLAG_C] = a[7];
        fo[FLAG_Z] = (r == 8'h00);
      end
      CMD_RR, CMD_SRA, CMD_SRL: begin
        case (cmd)
          CMD_RR:  r = {f[FLAG_C], a[7:1]};
          CMD_SRA: r = {a[7], a[7:1]};
          default: r = {1'b0, a[7:1]};
        endcase
        fo = 4'h0;
        fo[FLAG_C] = a[0];
        fo[FLAG_Z] = (r == 8'h00);
      end
      CMD_SWAP: begin
        r  = {a[3:0], a[7:4]};
        fo = 4'h0;
        fo[FLAG_Z] = (r == 8'h00);
      end
      CMD_BIT: begin
        r  = a;
        fo = 4'h0;
        fo[FLAG_C] = f[FLAG_C];
        fo[FLAG_H] = 1'b1;
        fo[FLAG_Z] = !a[bi];
      end
      CMD_RES: begin
        r     = a;
        r[bi] = 1'b0;
      end
      CMD_SET: begin
        r     = a;
        r[bi] = 1'b1;
      end
      CMD_DAA: begin
        ut = ua;
        if (!f[FLAG_N]) begin
          if (f[FLAG_H] || (ut & 15) > 9) ut = ut + 'h06;
          if (f[FLAG_C] || ut > 'h9F) ut = ut + 'h60;
        end else begin
          if (f[FLAG_H]) ut = (ut - 'h06) & 'hFF;
          if (f[FLAG_C]) ut = (ut - 'h60) & 'h1FF;
        end
        r = ut[7:0];
        fo[FLAG_H] = 1'b0;
        fo[FLAG_C] = f[FLAG_C] | ut[8];
        fo[FLAG_Z] = (r == 8'h00);
      end
      CMD_ADD16: begin
        wide = 1'b1;
        ut   = int'(x) + int'(y);
        rv   = ut[15:0];
        fo[FLAG_N] = 1'b0;
        fo[FLAG_H] = (int'(x[11:0]) + int'(y[11:0])) > 4095;
        fo[FLAG_C] = ut > 65535;
      end
      CMD_ADDSP: begin
        wide = 1'b1;
        ut   = int'(x) + (y[7] ? (int'(y[7:0]) - 256) : int'(y[7:0]));
        rv   = ut[15:0];
        fo   = 4'h0;
        fo[FLAG_H] = (int'(x[3:0]) + int'(y[3:0])) > 15;
        fo[FLAG_C] = (int'(x[7:0]) + int'(y[7:0])) > 255;
      end
      CMD_INC16: begin
        wide = 1'b1;
        rv   = x + 16'd1;
      end
      CMD_DEC16: begin
        wide = 1'b1;
        rv   = x - 16'd1;
      end
      default: begin
        // codes past the last operation: zero value, flags untouched
        wide = 1'b1;
        rv   = 16'h0000;
      end
    endcase

    e.cmd   = cmd;
    e.x     = x;
    e.y     = y;
    e.value = wide ? rv : {8'h00, r};
    e.flags = fo;
    return e;
  endfunction

  task note_failure(input string msg);
    errors++;
    if (errors <= 10) $display("[%0t] mismatch %0d: %s", $realtime, errors, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alu_results_q.delete();
      pending_o    <= 0;
      fail_count_o <= errors;
      checked_o    <= checked;
    end else begin
      // retire before accepting: the pipe never returns a result in its own cycle
      if ($isunknown(done_i)) begin
        note_failure("result strobe is unknown");
      end else if (done_i) begin
        if (alu_results_q.size() == 0) begin
          note_failure($sformatf("result %h/%h with no transaction outstanding",
                                 result_value_i, flags_out_i));
        end else begin
          head = alu_results_q.pop_front();
          checked++;
          if (result_value_i !== head.value)
            note_failure($sformatf("cmd %0d x %h y %h: value exp %h got %h",
                                   head.cmd, head.x, head.y, head.value, result_value_i));
          if (flags_out_i !== head.flags)
            note_failure($sformatf("cmd %0d x %h y %h: flags exp %b got %b",
                                   head.cmd, head.x, head.y, head.flags, flags_out_i));
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0)
        alu_results_q.push_back(alu_compute(command_i, first_operand_i, second_operand_i,
                                            bit_index_i, flags_in_i));
      pending_o    <= alu_results_q.size();
      fail_count_o <= errors;
      checked_o    <= checked;
    end
  end

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top-level bench for the handheld CPU ALU: drives directed corner cases of
// every command code, then bursts of random transactions with random gaps,
// while a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hcalu_pkg::*;

  localparam int ITEMS        = 500;    // random transactions after the directed set
  localparam int LIMIT        = 20000;  // cycle budget, many times the slowest run
  localparam int DRAIN_CYCLES = 8;      // pipe is 3 deep; a few spare cycles at the end

  // stimulus side, every input known from time zero
  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        start          = 1'b0;
  logic [4:0]  command        = '0;
  logic [15:0] first_operand  = '0;
  logic [15:0] second_operand = '0;
  logic [2:0]  bit_index      = '0;
  logic [3:0]  flags_in       = '0;

  logic        busy;
  logic        done;
  logic [15:0] result_value;
  logic [3:0]  flags_out;

  int          fail_count;
  int          pending_count;
  int          checked_count;
  int          cycles     = 0;
  int          sent       = 0;
  logic [31:0] seen_cmds  = '0;   // one bit per command code issued

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  handheld_cpu_alu_with_flags dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_o           (busy),
    .command_i        (command),
    .first_operand_i  (first_operand),
    .second_operand_i (second_operand),
    .bit_index_i      (bit_index),
    .flags_in_i       (flags_in),
    .done_o           (done),
    .result_value_o   (result_value),
    .flags_out_o      (flags_out)
  );

  alu_flag_checker chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .command_i        (command),
    .first_operand_i  (first_operand),
    .second_operand_i (second_operand),
    .bit_index_i      (bit_index),
    .flags_in_i       (flags_in),
    .done_i           (done),
    .result_value_i   (result_value),
    .flags_out_i      (flags_out),
    .fail_count_o     (fail_count),
    .pending_o        (pending_count),
    .checked_o        (checked_count)
  );

  // watchdog: a hung pipe or a lost result ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("watchdog: %0d cycles elapsed, %0d results outstanding",
               cycles, pending_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one transaction and hold it until the edge that takes it.
  // start stays high if the next call follows straight on.
  task issue(input logic [4:0] c, input logic [15:0] x, input logic [15:0] y,
             input logic [2:0] b, input logic [3:0] f);
    start          <= 1'b1;
    command        <= c;
    first_operand  <= x;
    second_operand <= y;
    bit_index      <= b;
    flags_in       <= f;
    do @(posedge clk); while (busy !== 1'b0);
    sent++;
    seen_cmds[c] = 1'b1;
  endtask

  // Idle with start low for the length given by n; the payload wiggles meanwhile and must be ignored.
  task pause(input int n);
    start          <= 1'b0;
    command        <= 5'($urandom);
    first_operand  <= 16'($urandom);
    second_operand <= 16'($urandom);
    bit_index      <= 3'($urandom);
    flags_in       <= 4'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // Hold off until every accepted transaction has come back.
  // The first edge lets the checker's count catch up with the last accept.
  task drain_pipe();
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Operand mix: plain random words plus the byte and nibble corners that
  // drive carries, half carries and the decimal-adjust paths.
  function automatic logic [15:0] pick_operand();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(0, 7))
      0: w = 16'h0000;
      1: w = 16'hFFFF;
      2: w[7:0]  = w[8] ? 8'hF0 : 8'h0F;
      3: w[7:0]  = w[9] ? 8'h7F : 8'h80;
      4: w[11:0] = {12{w[12]}};                 // 12-bit carry edge for add16
      5: begin                                  // packed BCD byte
        w[7:4] = w[7:4] % 10;
        w[3:0] = w[3:0] % 10;
      end
      default: ;
    endcase
    return w;
  endfunction

  task issue_random();
    logic [4:0] c;
    // now and then a code past the last operation
    if ($urandom_range(0, 15) == 0)
      c = 5'($urandom_range(31, int'(CMD_DEC16) + 1));
    else
      c = 5'($urandom_range(int'(CMD_DEC16), 0));
    issue(c, pick_operand(), pick_operand(), 3'($urandom), 4'($urandom));
  endtask

  initial begin
    int  n;
    int  burst;
    int  gap;
    bit  drained;

    n       = 0;
    drained = 1'b0;

    // single reset at the start of the run
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every command code once, operands at all-zero/all-ones,
    // bit index and incoming flags stepping through every value.
    // inc16 on 0xFFFF and dec16 on 0x0000 land here and wrap.
    for (int c = 0; c < 32; c++)
      issue(5'(c), c[0] ? 16'h0000 : 16'hFFFF, c[1] ? 16'h0000 : 16'hFFFF,
            3'(c), 4'(~c));

    // decimal adjust: add path carrying out to zero, subtract path with
    // both borrows, and a value needing no adjust
    issue(CMD_DAA,   16'h009A, 16'h0000, 3'd0, 4'b0000);
    issue(CMD_DAA,   16'h0000, 16'h0000, 3'd0, 4'b0111);  // N H C
    issue(CMD_DAA,   16'h0045, 16'h0000, 3'd0, 4'b1000);  // Z only, result nonzero
    // stack-pointer add with a negative offset and with a nibble carry
    issue(CMD_ADDSP, 16'hFFF8, 16'h0080, 3'd0, 4'b1111);
    issue(CMD_ADDSP, 16'h000F, 16'h00F1, 3'd0, 4'b0000);
    // 16-bit add: carry out of bit 11 only, Z passes through
    issue(CMD_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'b1111);
    // bit test of a set bit, compare of equal bytes, rotate-a on zero
    issue(CMD_BIT,   16'h0080, 16'h0000, 3'd7, 4'b0000);
    issue(CMD_CP,    16'h1234, 16'hAB34, 3'd0, 4'b0000);
    issue(CMD_RLCA,  16'h0000, 16'h0000, 3'd0, 4'b1111);

    // let the pipe run dry once before the random part
    drain_pipe();

    // Random bursts with random gaps; some bursts follow back to back.
    while (n < ITEMS) begin
      burst = $urandom_range(1, 32);
      for (int k = 0; k < burst && n < ITEMS; k++) begin
        issue_random();
        n++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (!drained && n >= ITEMS / 2) begin
        drain_pipe();
        drained = 1'b1;
      end else if (gap > 0) begin
        pause(gap);
      end
    end

    // wait for the tail, then a few more cycles for anything unexpected
    drain_pipe();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d transactions sent, %0d results checked, %0d of 32 command codes used",
             sent, checked_count, $countones(seen_cmds));
    $display("mismatches: %0d, results still outstanding: %0d",
             fail_count, pending_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/hcalu_pkg.sv
sv/hcalu_prep.sv
sv/hcalu_exec.sv
sv/hcalu_fin.sv
sv/handheld_cpu_alu_with_flags.sv
dv/alu_flag_checker.sv
dv/tb.sv
